// ----- rtl/core/bmrf_pkg.sv -----
// Package for the bitmap run finder: sizes, item structs, command codes,
// sequencer states and the bitmap memory request.
// Depends on nothing; every other file of the block uses it.
package bmrf_pkg;

	localparam int BITS      = 1024;
	localparam int WORD_W    = 32;
	localparam int NUM_WORDS = BITS / WORD_W;
	localparam int WORD_AW   = $clog2(NUM_WORDS);
	localparam int BIT_AW    = $clog2(WORD_W);
	localparam int SIZE_W    = 11;
	localparam int IDX_W     = 10;
	localparam int CMD_W     = 2;

	localparam logic [SIZE_W-1:0] BITS_IN_USE_RESET = SIZE_W'(1024);

	typedef enum logic [CMD_W-1:0] {
		CMD_SET        = 2'd0,
		CMD_READ       = 2'd1,
		CMD_FIND_CLEAR = 2'd2,
		CMD_FIND_SET   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_SCAN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] bit_index;
	} in_item_t;

	typedef struct packed {
		logic              bit_value;
		logic              run_found;
		logic [SIZE_W-1:0] run_start;
		logic [IDX_W-1:0]  run_end;
		logic              index_error;
	} out_item_t;

	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [WORD_AW-1:0] addr;
		logic [WORD_W-1:0]  wdata;
	} mem_req_t;

endpackage

// ----- rtl/core/bmrf_bitmap.sv -----
// Bitmap storage of the run finder: one RAM of 32-bit words with registered
// read data and one valid bit per word, so that unwritten words read as zero.
// Depends on bmrf_pkg.
module bmrf_bitmap (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bmrf_pkg::mem_req_t         req,
	output logic [bmrf_pkg::WORD_W-1:0] rword
);

	logic [bmrf_pkg::WORD_W-1:0]    mem_q [bmrf_pkg::NUM_WORDS];
	logic [bmrf_pkg::NUM_WORDS-1:0] wvalid_q;
	logic [bmrf_pkg::WORD_W-1:0]    rdata_q;
	logic                           rvalid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				wvalid_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= wvalid_q[req.addr];
			end
		end
	end

	assign rword = rvalid_q ? rdata_q : '0;

endmodule

// ----- rtl/core/bmrf_prienc.sv -----
// Shared priority encoder of the run finder: position of the lowest set bit
// of one bitmap word, with a flag that any bit is set.
// Depends on bmrf_pkg.
module bmrf_prienc (
	input  logic [bmrf_pkg::WORD_W-1:0] vec,
	output logic                        found,
	output logic [bmrf_pkg::BIT_AW-1:0] pos
);

	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = bmrf_pkg::WORD_W - 1; i >= 0; i--) begin
			if (vec[i]) begin
				found = 1'b1;
				pos   = bmrf_pkg::BIT_AW'(i);
			end
		end
	end

endmodule

// ----- rtl/core/bitmap_run_finder_core.sv -----
// Top level of the bitmap run finder: command sequencer, configuration
// register and result register. Depends on bmrf_pkg, bmrf_bitmap, bmrf_prienc.
//
// The block keeps a 1024-bit flag bitmap, clear after reset with no clearing
// pass, and takes one command at a time. A set or read whose index is in use
// goes from the accepting edge through the bitmap RAM read and the access
// state to the result state. An out-of-range set or read, or a find with no
// position in use, goes straight to the result state. A find walks the bitmap
// one 32-bit word per cycle through a single shared priority encoder, and the
// word where a run starts below its top bit is searched again for its end.
// The input stalls until the result has been loaded into the output register.
// A configuration write is taken only while the block is idle, no input is
// offered and no result is pending.
module bitmap_run_finder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bmrf_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bmrf_pkg::out_item_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bmrf_pkg::SIZE_W-1:0]   cfg_data
);

	localparam logic [bmrf_pkg::WORD_W-1:0] ONES = '1;

	bmrf_pkg::state_t    state_q, state_nx;
	bmrf_pkg::mem_req_t  mem_req;
	bmrf_pkg::out_item_t res_q, res_nx;
	bmrf_pkg::out_item_t out_q;
	bmrf_pkg::in_item_t  item_q;

	logic [bmrf_pkg::SIZE_W-1:0]  bits_q;
	logic [bmrf_pkg::SIZE_W-1:0]  size;
	logic [bmrf_pkg::SIZE_W-1:0]  size_m1;
	logic [bmrf_pkg::WORD_AW-1:0] last_word;
	logic [bmrf_pkg::BIT_AW-1:0]  last_bit;
	logic [bmrf_pkg::WORD_W-1:0]  rword;
	logic [bmrf_pkg::WORD_W-1:0]  match;
	logic [bmrf_pkg::WORD_W-1:0]  in_range;
	logic [bmrf_pkg::WORD_W-1:0]  enc_vec;
	logic                         enc_found;
	logic [bmrf_pkg::BIT_AW-1:0]  enc_pos;
	logic [bmrf_pkg::IDX_W-1:0]   enc_index;

	logic [bmrf_pkg::WORD_AW-1:0] word_q, word_nx;
	logic [bmrf_pkg::BIT_AW-1:0]  from_q, from_nx;
	logic                         phase_q, phase_nx;
	logic                         want_q;
	logic [bmrf_pkg::SIZE_W-1:0]  start_q, start_nx;
	logic                         out_valid_q;
	logic                         accept;
	logic                         out_load;
	logic                         idx_bad;
	logic                         is_find;
	logic                         scan_done;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != bmrf_pkg::ST_IDLE);
	assign cfg_ready = (state_q == bmrf_pkg::ST_IDLE) && !in_valid && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == bmrf_pkg::ST_RESULT) && (!out_valid_q || !out_stall);

	assign size      = (bits_q > bmrf_pkg::SIZE_W'(bmrf_pkg::BITS)) ?
	                   bmrf_pkg::SIZE_W'(bmrf_pkg::BITS) : bits_q;
	assign size_m1   = size - bmrf_pkg::SIZE_W'(1);
	assign last_word = size_m1[bmrf_pkg::BIT_AW +: bmrf_pkg::WORD_AW];
	assign last_bit  = size_m1[bmrf_pkg::BIT_AW-1:0];
	assign idx_bad   = bmrf_pkg::SIZE_W'(in_data.bit_index) >= size;
	assign is_find   = (bmrf_pkg::cmd_t'(in_data.cmd) == bmrf_pkg::CMD_FIND_CLEAR) ||
	                   (bmrf_pkg::cmd_t'(in_data.cmd) == bmrf_pkg::CMD_FIND_SET);

	assign match     = want_q ? rword : ~rword;
	assign in_range  = (word_q == last_word) ?
	                   (ONES >> (bmrf_pkg::BIT_AW'(bmrf_pkg::WORD_W - 1) - last_bit)) : ONES;
	assign enc_vec   = (phase_q ? ~(match & in_range) : (match & in_range)) & (ONES << from_q);
	assign enc_index = {word_q, enc_pos};

	bmrf_bitmap u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rword  (rword)
	);

	bmrf_prienc u_prienc (
		.vec   (enc_vec),
		.found (enc_found),
		.pos   (enc_pos)
	);

	// A scan step ends the search when the run end is seen or the last word is passed.
	assign scan_done = (phase_q && enc_found) || (word_q == last_word &&
	                   (!enc_found || (!phase_q && enc_pos == bmrf_pkg::BIT_AW'(bmrf_pkg::WORD_W - 1))));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bmrf_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_find) begin
						state_nx = (size == '0) ? bmrf_pkg::ST_RESULT : bmrf_pkg::ST_SCAN;
					end else begin
						state_nx = idx_bad ? bmrf_pkg::ST_RESULT : bmrf_pkg::ST_ACCESS;
					end
				end
			end
			bmrf_pkg::ST_ACCESS: begin
				state_nx = bmrf_pkg::ST_RESULT;
			end
			bmrf_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_nx = bmrf_pkg::ST_RESULT;
				end
			end
			bmrf_pkg::ST_RESULT: begin
				if (out_load) begin
					state_nx = bmrf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = bmrf_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_req  = '0;
		res_nx   = res_q;
		word_nx  = word_q;
		from_nx  = from_q;
		phase_nx = phase_q;
		start_nx = start_q;
		unique case (state_q)
			bmrf_pkg::ST_IDLE: begin
				word_nx  = '0;
				from_nx  = '0;
				phase_nx = 1'b0;
				res_nx   = '0;
				if (accept) begin
					if (is_find) begin
						mem_req.rd_en     = 1'b1;
						res_nx.run_start  = size;
					end else if (idx_bad) begin
						res_nx.index_error = 1'b1;
					end else begin
						mem_req.rd_en = 1'b1;
						mem_req.addr  = in_data.bit_index[bmrf_pkg::BIT_AW +: bmrf_pkg::WORD_AW];
					end
				end
			end
			bmrf_pkg::ST_ACCESS: begin
				mem_req.addr = item_q.bit_index[bmrf_pkg::BIT_AW +: bmrf_pkg::WORD_AW];
				if (bmrf_pkg::cmd_t'(item_q.cmd) == bmrf_pkg::CMD_SET) begin
					mem_req.wr_en = 1'b1;
					mem_req.wdata = rword |
						(bmrf_pkg::WORD_W'(1) << item_q.bit_index[bmrf_pkg::BIT_AW-1:0]);
				end else begin
					res_nx.bit_value = rword[item_q.bit_index[bmrf_pkg::BIT_AW-1:0]];
				end
			end
			bmrf_pkg::ST_SCAN: begin
				if (!phase_q && enc_found) begin
					start_nx = bmrf_pkg::SIZE_W'(enc_index);
					phase_nx = 1'b1;
					from_nx  = enc_pos + bmrf_pkg::BIT_AW'(1);
				end
				if (phase_q && enc_found) begin
					res_nx.run_found = 1'b1;
					res_nx.run_start = start_q;
					res_nx.run_end   = enc_index - bmrf_pkg::IDX_W'(1);
				end else if (scan_done) begin
					if (phase_q || enc_found) begin
						res_nx.run_found = 1'b1;
						res_nx.run_start = phase_q ? start_q : bmrf_pkg::SIZE_W'(enc_index);
						res_nx.run_end   = bmrf_pkg::IDX_W'(size_m1);
					end
				end else if (!enc_found ||
				             enc_pos == bmrf_pkg::BIT_AW'(bmrf_pkg::WORD_W - 1)) begin
					word_nx       = word_q + bmrf_pkg::WORD_AW'(1);
					from_nx       = '0;
					mem_req.rd_en = 1'b1;
					mem_req.addr  = word_q + bmrf_pkg::WORD_AW'(1);
				end
			end
			bmrf_pkg::ST_RESULT: begin
				res_nx = res_q;
			end
			default: begin
				res_nx = res_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmrf_pkg::ST_IDLE;
			bits_q      <= bmrf_pkg::BITS_IN_USE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				bits_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q   <= res_nx;
		word_q  <= word_nx;
		from_q  <= from_nx;
		phase_q <= phase_nx;
		start_q <= start_nx;
		if (accept) begin
			item_q <= in_data;
			want_q <= (bmrf_pkg::cmd_t'(in_data.cmd) == bmrf_pkg::CMD_FIND_SET);
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bmrf_pkg::ST_SCAN |-> word_q <= last_word)
		else $error("Scan went past the last word in use.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != bmrf_pkg::ST_IDLE)
		else $error("Accepted transaction did not start the sequencer.");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.run_found |->
			out_q.run_start[bmrf_pkg::IDX_W-1:0] <= out_q.run_end &&
			out_q.run_start < size)
		else $error("Reported run is malformed.");

	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd_en && mem_req.wr_en))
		else $error("Bitmap read and write in the same cycle.");

endmodule
